FILE: hdl/spq_pkg.sv
`timescale 1ns / 1ps
package spq_pkg;

    localparam int DEPTH   = 64;
    localparam int CNT_W   = 7;
    localparam int VAL_W   = 32;
    localparam int PRIO_W  = 32;
    localparam int STAT_W  = 2;

    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    typedef struct packed {
        logic                     ins;
        logic                     rem;
        logic signed [VAL_W-1:0]  value;
        logic signed [PRIO_W-1:0] key;
    } t_cell_ctrl;

endpackage

FILE: hdl/sorted_priority_queue.sv
`timescale 1ns / 1ps
// a result beat is registered and appears in the cycle after its request beat is taken
// throughput: one request per cycle while the output is not stalled; every cell compares and shifts in parallel
// the head of the cell chain feeds the output register directly
// reset (synchronous, active low) empties the queue, drops any pending result
// and sets capacity to 64; cell contents are not cleared
module sorted_priority_queue (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [spq_pkg::CNT_W-1:0]         i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_req_type,
    input  logic signed [spq_pkg::VAL_W-1:0]  i_value_in,
    input  logic signed [spq_pkg::PRIO_W-1:0] i_priority_in,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [spq_pkg::STAT_W-1:0]        o_status,
    output logic signed [spq_pkg::VAL_W-1:0]  o_value_out,
    output logic [spq_pkg::CNT_W-1:0]         o_occupancy
);
    import spq_pkg::*;

    logic [CNT_W-1:0]         r_cap;
    logic [CNT_W-1:0]         r_count, n_count;
    logic                     r_out_valid;
    logic [STAT_W-1:0]        r_status, n_status;
    logic signed [VAL_W-1:0]  r_value_out, n_value_out;
    logic [CNT_W-1:0]         r_occ;

    logic                     in_beat;
    logic                     full;
    logic [CNT_W-1:0]         cap_eff;
    t_cell_ctrl               ctrl;

    logic                     gt    [DEPTH];
    logic signed [VAL_W-1:0]  value [DEPTH];
    logic signed [PRIO_W-1:0] prio  [DEPTH];

    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_beat    = i_in_valid && !o_in_stall;
    assign cap_eff    = (r_cap > DEPTH_CNT) ? DEPTH_CNT : r_cap;
    assign full       = r_count >= cap_eff;

    always_comb begin
        ctrl.ins    = in_beat && (i_req_type == REQ_INSERT) && !full;
        ctrl.rem    = in_beat && (i_req_type == REQ_REMOVE) && (r_count != '0);
        ctrl.value  = i_value_in;
        ctrl.key    = i_priority_in;
        n_count     = r_count;
        n_status    = STAT_DONE;
        n_value_out = '0;
        if (i_req_type == REQ_INSERT) begin
            if (full) begin
                n_status = STAT_FULL;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end else begin
            if (r_count == '0) begin
                n_status = STAT_EMPTY;
            end else begin
                n_count     = r_count - CNT_W'(1);
                n_value_out = value[0];
            end
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        spq_cell u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (ctrl),
            .i_occupied    (CNT_W'(g) < r_count),
            .i_left_gt     ((g == 0) ? 1'b0 : gt[(g == 0) ? 0 : g-1]),
            .i_left_value  ((g == 0) ? '0 : value[(g == 0) ? 0 : g-1]),
            .i_left_prio   ((g == 0) ? '0 : prio[(g == 0) ? 0 : g-1]),
            .i_right_value (value[(g == DEPTH-1) ? g : g+1]),
            .i_right_prio  (prio[(g == DEPTH-1) ? g : g+1]),
            .o_gt          (gt[g]),
            .o_value       (value[g]),
            .o_prio        (prio[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CAP_RESET;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            if (in_beat) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_status    <= n_status;
            r_value_out <= n_value_out;
            r_occ       <= n_count;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_value_out = r_value_out;
    assign o_occupancy = r_occ;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_CNT)
        else $error("entry count above depth");

    a_occ_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (o_occupancy == r_count))
        else $error("reported occupancy differs from entry count");

    a_full_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_beat && (i_req_type == REQ_INSERT) && full) |=>
        (o_status == STAT_FULL) && (r_count == $past(r_count)))
        else $error("insert into full queue not reported");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (o_status != STAT_DONE)) |-> (o_value_out == '0))
        else $error("nonzero value on failed request");

endmodule

FILE: hdl/spq_cell.sv
`timescale 1ns / 1ps
module spq_cell (
    input  logic                              i_clk,
    input  spq_pkg::t_cell_ctrl               i_ctrl,
    input  logic                              i_occupied,
    input  logic                              i_left_gt,
    input  logic signed [spq_pkg::VAL_W-1:0]  i_left_value,
    input  logic signed [spq_pkg::PRIO_W-1:0] i_left_prio,
    input  logic signed [spq_pkg::VAL_W-1:0]  i_right_value,
    input  logic signed [spq_pkg::PRIO_W-1:0] i_right_prio,
    output logic                              o_gt,
    output logic signed [spq_pkg::VAL_W-1:0]  o_value,
    output logic signed [spq_pkg::PRIO_W-1:0] o_prio
);
    import spq_pkg::*;

    logic signed [VAL_W-1:0]  r_value, n_value;
    logic signed [PRIO_W-1:0] r_prio,  n_prio;

    // slot is past the insert point: empty, or strictly later priority
    assign o_gt = !i_occupied || (r_prio > i_ctrl.key);

    always_comb begin
        n_value = r_value;
        n_prio  = r_prio;
        if (i_ctrl.ins) begin
            if (i_left_gt) begin
                n_value = i_left_value;
                n_prio  = i_left_prio;
            end else if (o_gt) begin
                n_value = i_ctrl.value;
                n_prio  = i_ctrl.key;
            end
        end else if (i_ctrl.rem) begin
            n_value = i_right_value;
            n_prio  = i_right_prio;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_prio  <= n_prio;
    end

    assign o_value = r_value;
    assign o_prio  = r_prio;

endmodule
